// File: sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Operation codes, controller states, sweep modes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Character and attribute constants
  localparam logic [7:0] SPACE_CHAR      = 8'h20;
  localparam logic [7:0] NULL_CHAR       = 8'h00;
  localparam logic [7:0] LINE_FEED       = 8'd10;
  localparam logic [7:0] CARRIAGE_RETURN = 8'd13;
  localparam logic [7:0] ATTR_RESET      = 8'd7;

  // Request codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_BOOT,
    ST_WIPE,
    ST_IDLE,
    ST_ERASE,
    ST_READ,
    ST_SWEEP
  } state_e;

  // What a full-screen sweep writes
  typedef enum logic [1:0] {
    SW_ZERO,
    SW_SPACE,
    SW_SCROLL
  } sweep_e;

  // Controller to datapath
  typedef struct packed {
    logic   cur_put;     // store char (unless line break) and advance cursor
    logic   cur_back;    // step cursor back and fetch the cell under it
    logic   cur_home;    // cursor to origin
    logic   rd_index;    // fetch the cell named by cell_index
    logic   wr_erase;    // write back fetched cell with its char zeroed
    logic   sweep_start; // start a full-screen sweep
    sweep_e sweep_mode;
    logic   res_emit;    // present a result next cycle
    logic   res_read;    // result carries the fetched cell
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic put_scroll;  // a put now would pass the last row
    logic at_origin;   // cursor at row 0, column 0
    logic sweep_done;  // no sweep in flight
  } dp_status_t;

endpackage : tcw_pkg
`default_nettype wire

// File: sv/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text screen of character/attribute cells with cursor
// Puts, erases, clears and reads cells of a COLUMNS by ROWS screen; every
// request reports the cursor position after it.
//
//   Channel   Direction  Signals                                   Transaction
//   request   in         start, busy, operation_i, char_code_i,    start & !busy
//                        cell_index_i
//   result    out        done_o, cursor_col_o, cursor_row_o,       done_o (1 cycle)
//                        read_char_o, read_attr_o
//   config    in         text_attribute_we_i, text_attribute_i     we high
//
// A put without scroll, or an erase at the origin, keeps busy low: done_o
// pulses in the next cycle. Erase and read first read the cell into a
// register, then write it back or report it. Clear and scroll sweep the
// store one cell per cycle. After reset the same sweep zeroes the store
// with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_index_i,
  input  wire logic        text_attribute_we_i,
  input  wire logic [7:0]  text_attribute_i,
  output logic             done_o,
  output logic [6:0]       cursor_col_o,
  output logic [4:0]       cursor_row_o,
  output logic [7:0]       read_char_o,
  output logic [7:0]       read_attr_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Request sequencer
  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op_e'(operation_i)),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  // Screen store, cursor and results
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_we_i    (text_attribute_we_i),
    .attr_wdata_i (text_attribute_i),
    .done_o       (done_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .read_char_o  (read_char_o),
    .read_attr_o  (read_attr_o)
  );

endmodule : text_console_writer
`default_nettype wire

// File: sv/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: request sequencer of the text console writer
// Accepts one request at a time, steps the datapath through its memory
// accesses and sweeps, and asks for the result at the end.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire op_e        op_i,
  input  wire dp_status_t status_i,
  output logic            busy_o,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_BOOT: state_d = ST_WIPE;
      ST_WIPE: begin
        if (status_i.sweep_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_PUT:   if (status_i.put_scroll) state_d = ST_SWEEP;
            OP_ERASE: if (!status_i.at_origin) state_d = ST_ERASE;
            OP_CLEAR: state_d = ST_SWEEP;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ERASE: state_d = ST_IDLE;
      ST_READ:  state_d = ST_IDLE;
      ST_SWEEP: begin
        if (status_i.sweep_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.sweep_mode = SW_ZERO;
    case (state_q)
      ST_BOOT: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_mode  = SW_ZERO;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_PUT: begin
              cmd_o.cur_put = 1'b1;
              if (status_i.put_scroll) begin
                cmd_o.sweep_start = 1'b1;
                cmd_o.sweep_mode  = SW_SCROLL;
              end else begin
                cmd_o.res_emit = 1'b1;
              end
            end
            OP_ERASE: begin
              if (status_i.at_origin) begin
                cmd_o.res_emit = 1'b1;
              end else begin
                cmd_o.cur_back = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd_o.cur_home    = 1'b1;
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_mode  = SW_SPACE;
            end
            OP_READ: cmd_o.rd_index = 1'b1;
            default: cmd_o.res_emit = 1'b1;
          endcase
        end
      end
      ST_ERASE: begin
        cmd_o.wr_erase = 1'b1;
        cmd_o.res_emit = 1'b1;
      end
      ST_READ: begin
        cmd_o.res_emit = 1'b1;
        cmd_o.res_read = 1'b1;
      end
      ST_SWEEP: begin
        cmd_o.res_emit = status_i.sweep_done;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule : tcw_ctrl
`default_nettype wire

// File: sv/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and sweep engine
// Holds the cell memory (one write and one registered read per cycle), the
// cursor with its linear cell address, the attribute register, the sweep
// counter used for wipe, clear and scroll, and the result registers.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_index_i,
  input  wire logic        attr_we_i,
  input  wire logic [7:0]  attr_wdata_i,
  output logic             done_o,
  output logic [6:0]       cursor_col_o,
  output logic [4:0]       cursor_row_o,
  output logic [7:0]       read_char_o,
  output logic [7:0]       read_attr_o
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [CNT_W-1:0]  SW_LAST     = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0]  SW_TOP_END  = CNT_W'(CELL_COUNT - COLUMNS);
  localparam logic [CNT_W-1:0]  SW_STRIDE   = CNT_W'(COLUMNS);

  // Cell store: attribute in the high byte, character in the low byte
  logic [15:0] mem_q [CELL_COUNT];
  logic [15:0] rdata_q;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [7:0] attr_q;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic              sw_run_q;
  sweep_e            sw_mode_q;
  logic [CNT_W-1:0]  sw_q;
  logic              pend_q;
  logic [ADDR_W-1:0] pend_addr_q;
  logic              pend_top_q;
  logic              sw_top;
  logic [15:0]       pend_wdata;

  logic rd_ok_q;
  logic is_break;
  logic at_last_col;
  logic at_last_row;

  logic       res_valid_q;
  logic [6:0] res_col_q;
  logic [4:0] res_row_q;
  logic [7:0] res_char_q;
  logic [7:0] res_attr_q;

  assign is_break    = (char_code_i == LINE_FEED) || (char_code_i == CARRIAGE_RETURN);
  assign at_last_col = (col_q == LAST_COL);
  assign at_last_row = (row_q == LAST_ROW);

  assign status_o.put_scroll = at_last_row && (is_break || at_last_col);
  assign status_o.at_origin  = (col_q == '0) && (row_q == '0);
  assign status_o.sweep_done = !sw_run_q && !pend_q;

  // Attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  // Cursor next value
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    addr_d = addr_q;
    if (cmd_i.cur_home) begin
      col_d  = '0;
      row_d  = '0;
      addr_d = '0;
    end else if (cmd_i.cur_put) begin
      if (is_break || at_last_col) begin
        col_d = '0;
        if (at_last_row) begin
          row_d  = LAST_ROW;
          addr_d = BOTTOM_ADDR;
        end else begin
          row_d  = row_q + 1'b1;
          addr_d = addr_q - ADDR_W'(col_q) + ROW_STRIDE;
        end
      end else begin
        col_d  = col_q + 1'b1;
        addr_d = addr_q + 1'b1;
      end
    end else if (cmd_i.cur_back) begin
      // Stepping back across a row edge is also one cell back in memory
      addr_d = addr_q - 1'b1;
      if (col_q == '0) begin
        col_d = LAST_COL;
        row_d = row_q - 1'b1;
      end else begin
        col_d = col_q - 1'b1;
      end
    end
  end

  // Cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      addr_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      addr_q <= addr_d;
    end
  end

  // Sweep engine: issue a read, write in the next cycle through the pending stage
  assign sw_top = (sw_q < SW_TOP_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_run_q   <= 1'b0;
      sw_mode_q  <= SW_ZERO;
      sw_q       <= '0;
      pend_q     <= 1'b0;
      pend_top_q <= 1'b0;
    end else begin
      pend_q <= sw_run_q;
      if (sw_run_q) begin
        pend_top_q <= sw_top;
      end
      if (cmd_i.sweep_start) begin
        sw_run_q  <= 1'b1;
        sw_mode_q <= cmd_i.sweep_mode;
        sw_q      <= '0;
      end else if (sw_run_q) begin
        sw_q <= sw_q + 1'b1;
        if (sw_q == SW_LAST) begin
          sw_run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_run_q) begin
      pend_addr_q <= ADDR_W'(sw_q);
    end
  end

  // Value the sweep writes into one cell
  always_comb begin
    case (sw_mode_q)
      SW_ZERO:   pend_wdata = 16'h0000;
      SW_SPACE:  pend_wdata = {attr_q, SPACE_CHAR};
      SW_SCROLL: pend_wdata = {attr_q, pend_top_q ? rdata_q[7:0] : NULL_CHAR};
      default:   pend_wdata = 16'h0000;
    endcase
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = {attr_q, char_code_i};
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_wdata;
    end else if (cmd_i.cur_put && !is_break) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = {attr_q, char_code_i};
    end else if (cmd_i.wr_erase) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = {rdata_q[15:8], NULL_CHAR};
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(cell_index_i);
    if (sw_run_q) begin
      mem_re    = sw_top;
      mem_raddr = ADDR_W'(sw_q + SW_STRIDE);
    end else if (cmd_i.cur_back) begin
      mem_re    = 1'b1;
      mem_raddr = addr_q - 1'b1;
    end else if (cmd_i.rd_index) begin
      mem_re    = (int'(cell_index_i) < CELL_COUNT);
      mem_raddr = ADDR_W'(cell_index_i);
    end
  end

  // Cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Read range check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (cmd_i.rd_index) begin
      rd_ok_q <= (int'(cell_index_i) < CELL_COUNT);
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_emit) begin
      res_col_q <= 7'(col_d);
      res_row_q <= 5'(row_d);
      if (cmd_i.res_read && rd_ok_q) begin
        res_char_q <= rdata_q[7:0];
        res_attr_q <= rdata_q[15:8];
      end else begin
        res_char_q <= '0;
        res_attr_q <= '0;
      end
    end
  end

  assign done_o       = res_valid_q;
  assign cursor_col_o = res_col_q;
  assign cursor_row_o = res_row_q;
  assign read_char_o  = res_char_q;
  assign read_attr_o  = res_attr_q;

endmodule : tcw_datapath
`default_nettype wire

// File: verif/text_console_writer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Drives put, erase, clear and read requests through the start/busy port. A
// shadow screen with its own cursor and attribute predicts every report, and
// each done_o strobe is checked field by field against the oldest prediction.
// A short table of hand-checked requests comes first. Three random phases
// follow, each with a different attribute and a different sender idle rate.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int SCREEN_COLS  = COLUMNS_DEF;
  localparam int SCREEN_ROWS  = ROWS_DEF;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int PHASE_ITEMS  = 570;
  localparam int STALL_LIMIT  = 12000;
  localparam int PRINT_CAP    = 40;
  localparam int NUM_PROBES   = 24;

  // One report: cursor after the request, plus the cell on a read
  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
  } cursor_report_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    op_e            op;
    logic [7:0]     ch;
    logic [10:0]    idx;
    logic           typed;
    cursor_report_t want;
  } console_probe_t;

  logic        clk_i;
  logic        rst_ni              = 1'b0;
  logic        start               = 1'b0;
  logic        busy;
  logic [1:0]  operation_i         = OP_PUT;
  logic [7:0]  char_code_i         = 8'h00;
  logic [10:0] cell_index_i        = 11'd0;
  logic        text_attribute_we_i = 1'b0;
  logic [7:0]  text_attribute_i    = 8'h00;
  logic        done_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [7:0]  read_char_o;
  logic [7:0]  read_attr_o;

  // Shadow of the screen, cursor and attribute register
  logic [15:0]    screen_model [SCREEN_CELLS];
  int unsigned    cur_col     = 0;
  int unsigned    cur_row     = 0;
  logic [7:0]     attr_shadow = ATTR_RESET;
  cursor_report_t pending_reports [$];

  int unsigned error_count     = 0;
  int unsigned stall_cycles    = 0;
  int unsigned sender_idle_pct = 0;

  // Directed requests, in order; attribute is still at its reset value
  console_probe_t probe_table [NUM_PROBES] = '{
    // store wiped by reset
    '{OP_READ,  8'h00,           11'd0,    1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    '{OP_READ,  8'hFF,           11'd1999, 1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    // read past the screen answers zero
    '{OP_READ,  8'h00,           11'h7FF,  1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    // erase at the origin does nothing
    '{OP_ERASE, 8'hFF,           11'h7FF,  1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    '{OP_PUT,   8'h41,           11'd0,    1'b1, '{7'd1,  5'd0, 8'h00,      8'h00}},
    '{OP_READ,  8'h00,           11'd0,    1'b1, '{7'd1,  5'd0, 8'h41,      ATTR_RESET}},
    '{OP_PUT,   8'hFF,           11'd0,    1'b1, '{7'd2,  5'd0, 8'h00,      8'h00}},
    '{OP_PUT,   8'h00,           11'd0,    1'b1, '{7'd3,  5'd0, 8'h00,      8'h00}},
    // erase zeroes the char and keeps the attribute
    '{OP_ERASE, 8'h00,           11'd0,    1'b1, '{7'd2,  5'd0, 8'h00,      8'h00}},
    '{OP_READ,  8'h00,           11'd2,    1'b1, '{7'd2,  5'd0, 8'h00,      ATTR_RESET}},
    '{OP_READ,  8'h00,           11'd1,    1'b1, '{7'd2,  5'd0, 8'hFF,      ATTR_RESET}},
    // both line breaks
    '{OP_PUT,   LINE_FEED,       11'd0,    1'b1, '{7'd0,  5'd1, 8'h00,      8'h00}},
    '{OP_PUT,   CARRIAGE_RETURN, 11'd0,    1'b1, '{7'd0,  5'd2, 8'h00,      8'h00}},
    // erase at column 0 wraps to the last column of the row above
    '{OP_ERASE, 8'h00,           11'd0,    1'b1, '{7'd79, 5'd1, 8'h00,      8'h00}},
    // put in the last column wraps the cursor
    '{OP_PUT,   8'h7E,           11'd0,    1'b1, '{7'd0,  5'd2, 8'h00,      8'h00}},
    '{OP_READ,  8'h00,           11'd159,  1'b1, '{7'd0,  5'd2, 8'h7E,      ATTR_RESET}},
    '{OP_PUT,   8'h80,           11'h400,  1'b0, '0},
    '{OP_READ,  8'h00,           11'd160,  1'b0, '0},
    '{OP_CLEAR, 8'h00,           11'd0,    1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    '{OP_READ,  8'h00,           11'd1999, 1'b1, '{7'd0,  5'd0, SPACE_CHAR, ATTR_RESET}},
    '{OP_READ,  8'h00,           11'd2000, 1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    '{OP_ERASE, 8'h00,           11'd0,    1'b1, '{7'd0,  5'd0, 8'h00,      8'h00}},
    '{OP_PUT,   8'h09,           11'h3FF,  1'b0, '0},
    '{OP_READ,  8'h00,           11'h7FF,  1'b0, '0}
  };

  text_console_writer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .operation_i         (operation_i),
    .char_code_i         (char_code_i),
    .cell_index_i        (cell_index_i),
    .text_attribute_we_i (text_attribute_we_i),
    .text_attribute_i    (text_attribute_i),
    .done_o              (done_o),
    .cursor_col_o        (cursor_col_o),
    .cursor_row_o        (cursor_row_o),
    .read_char_o         (read_char_o),
    .read_attr_o         (read_attr_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    for (int i = 0; i < SCREEN_CELLS; i++) screen_model[i] = 16'h0000;
  end

  task automatic note_failure(input string msg);
    if (error_count < PRINT_CAP) $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Apply one accepted request to the shadow screen and return its report
  function automatic cursor_report_t console_apply(input op_e op, input logic [7:0] ch,
                                                   input logic [10:0] idx);
    cursor_report_t rep;
    int unsigned    pos;
    rep = '0;
    case (op)
      OP_PUT: begin
        if (ch == LINE_FEED || ch == CARRIAGE_RETURN) begin
          cur_row++;
          cur_col = 0;
        end else begin
          screen_model[cur_row * SCREEN_COLS + cur_col] = {attr_shadow, ch};
          cur_col++;
          if (cur_col >= SCREEN_COLS) begin
            cur_row++;
            cur_col = 0;
          end
        end
        // passing the last row: shift up, restamp attributes, blank bottom row
        if (cur_row > SCREEN_ROWS - 1) begin
          for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
            screen_model[i] = {attr_shadow, screen_model[i + SCREEN_COLS][7:0]};
          for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
            screen_model[i] = {attr_shadow, 8'h00};
          cur_row = SCREEN_ROWS - 1;
          cur_col = 0;
        end
      end
      OP_ERASE: begin
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            cur_col = SCREEN_COLS - 1;
            cur_row--;
          end else begin
            cur_col--;
          end
          pos = cur_row * SCREEN_COLS + cur_col;
          screen_model[pos][7:0] = 8'h00;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SCREEN_CELLS; i++) screen_model[i] = {attr_shadow, SPACE_CHAR};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        if (idx < SCREEN_CELLS) begin
          rep.rd_char = screen_model[idx][7:0];
          rep.rd_attr = screen_model[idx][15:8];
        end
      end
    endcase
    rep.col = cur_col[6:0];
    rep.row = cur_row[4:0];
    return rep;
  endfunction

  // Present one request after a random gap, wait for it to be taken, predict
  task automatic issue_request(input op_e op, input logic [7:0] ch, input logic [10:0] idx,
                               input logic typed, input cursor_report_t want);
    int unsigned    gap;
    cursor_report_t rep;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy);
    rep = console_apply(op, ch, idx);
    pending_reports.push_back(typed ? want : rep);
  endtask

  // Hold the sender off until every report is in and the block is free
  task automatic drain_requests();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0 || busy);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    drain_requests();
    text_attribute_we_i <= 1'b1;
    text_attribute_i    <= value;
    @(posedge clk_i);
    text_attribute_we_i <= 1'b0;
    attr_shadow = value;
  endtask

  // Random traffic: mostly typed text, backspaces and reads around the cursor
  task automatic run_random_phase(input int unsigned target, input int unsigned idle_pct);
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    int unsigned here;
    int unsigned back;
    logic [10:0] idx;
    sent = 0;
    while (sent < target) begin
      sender_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
      if ($urandom_range(0, 39) == 0) drain_requests();
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // a run of text, usually ended by a line break
        n = $urandom_range(1, 120);
        repeat (n) issue_request(OP_PUT, 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)), 1'b0, '0);
        sent += n;
        if ($urandom_range(0, 9) < 7) begin
          issue_request(OP_PUT, $urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN,
                        11'($urandom_range(0, 2047)), 1'b0, '0);
          sent++;
        end
      end else if (kind < 56) begin
        // burst of line breaks to reach the bottom and scroll
        n = $urandom_range(3, 30);
        repeat (n) issue_request(OP_PUT, $urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN,
                                 11'($urandom_range(0, 2047)), 1'b0, '0);
        sent += n;
      end else if (kind < 70) begin
        n = $urandom_range(1, 8);
        repeat (n) issue_request(OP_ERASE, 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)), 1'b0, '0);
        sent += n;
      end else if (kind < 92) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          here = cur_row * SCREEN_COLS + cur_col;
          back = $urandom_range(0, 100);
          case ($urandom_range(0, 3))
            0:       idx = 11'($urandom_range(0, 2047));
            1:       idx = 11'($urandom_range(SCREEN_CELLS - 48, 2047));
            default: idx = (here >= back) ? 11'(here - back) : 11'(here);
          endcase
          issue_request(OP_READ, 8'($urandom_range(0, 255)), idx, 1'b0, '0);
        end
        sent += n;
      end else if (kind < 94) begin
        issue_request(OP_CLEAR, 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)), 1'b0, '0);
        sent++;
      end else begin
        // noise: any operation with any fields
        issue_request(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result checker: every strobe against the oldest prediction
  always @(posedge clk_i) begin
    cursor_report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        note_failure("result with no request outstanding");
      end else begin
        want = pending_reports.pop_front();
        if (cursor_col_o !== want.col)
          note_failure($sformatf("cursor_col got %0d want %0d", cursor_col_o, want.col));
        if (cursor_row_o !== want.row)
          note_failure($sformatf("cursor_row got %0d want %0d", cursor_row_o, want.row));
        if (read_char_o !== want.rd_char)
          note_failure($sformatf("read_char got %h want %h", read_char_o, want.rd_char));
        if (read_attr_o !== want.rd_attr)
          note_failure($sformatf("read_attr got %h want %h", read_attr_o, want.rd_attr));
      end
    end
  end

  // Watchdog: too long with no transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("text_console_writer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset attribute, no sender gaps
    sender_idle_pct = 0;
    for (int p = 0; p < NUM_PROBES; p++)
      issue_request(probe_table[p].op, probe_table[p].ch, probe_table[p].idx,
                    probe_table[p].typed, probe_table[p].want);

    write_attribute(8'h00);
    run_random_phase(PHASE_ITEMS, 32);
    write_attribute(8'hFF);
    run_random_phase(PHASE_ITEMS, 84);
    write_attribute(8'($urandom_range(1, 254)));
    run_random_phase(PHASE_ITEMS, 0);

    drain_requests();
    repeat (16) @(posedge clk_i);
    if (pending_reports.size() != 0) note_failure("requests left without a result");
    if (error_count == 0) begin
      $display("text_console_writer_tb OK");
    end else begin
      $display("text_console_writer_tb NOT OK");
    end
    $finish;
  end

endmodule : text_console_writer_tb
`default_nettype wire
